### rtl/core/vgm_pkg.sv
package vgm_pkg;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_FETCH   = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int CHUNK_SIZE   = 16;
  localparam int CHUNK_HEIGHT = 384;
  localparam int BLOCK_BITS   = 6;

  localparam int AIR_BITS  = 6;
  localparam int OUT_BITS  = 48;
  localparam int IN_BITS   = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRD,
    ST_BWR,
    ST_SRD,
    ST_SCHK,
    ST_WRD,
    ST_WCHK,
    ST_HRD,
    ST_HCHK,
    ST_CLR,
    ST_EMIT,
    ST_ADV,
    ST_DONE
  } state_t;

endpackage

### rtl/core/voxel_greedy_mesher.sv
// voxel chunk store with a greedy face mesher
// s_tuser carries the action: write voxel, restart sweep or fetch next quad.
// s_tdata carries the voxel coordinates and block code of a write.
// cfg_we/cfg_data set the air code; user must do so only while idle (unchecked).
// a write is stored when accepted, if voxel_z lies inside the chunk. a restart
// builds the face mask of the first slice boundary, one mask cell at a time in
// ST_BRD then ST_BWR, the two voxel memory read ports feeding one mask write.
// a fetch scans the mask from the cursor (ST_SRD, ST_SCHK), grows the
// rectangle (ST_WRD, ST_WCHK, ST_HRD, ST_HCHK), clears it in ST_CLR, and
// rebuilds the mask at every boundary it passes; each fetch returns exactly
// one item on m_tdata (quad_valid low once the sweep is exhausted).
// items are taken one at a time: s_tready is high only between items.
// a finished item waits in the output register; while the receiver stalls
// the next item may still be accepted, and a fetch waits for the register.
// reset clears the sweep (finished), the air code and the output valid flag.
// the voxel memory is not cleared; every voxel must be written before a sweep.
module voxel_greedy_mesher
  import vgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_BITS-1:0]   s_tdata,  // voxel_x, voxel_y, voxel_z, block_code
  input  logic [1:0]           s_tuser,  // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_BITS-1:0]  m_tdata,  // quad_valid, sweep_axis, facing_positive,
                                         // face_block, corner_x, corner_y, corner_z,
                                         // span_first, span_second
  input  logic                 cfg_we,
  input  logic [AIR_BITS-1:0]  cfg_data
);

  localparam int SD  = CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT;
  localparam int MD  = CHUNK_SIZE * (CHUNK_SIZE + CHUNK_HEIGHT);
  localparam int VW  = $clog2(SD);
  localparam int MW  = $clog2(MD);
  localparam int MX  = (CHUNK_SIZE > CHUNK_HEIGHT) ? CHUNK_SIZE : CHUNK_HEIGHT;
  localparam int LW  = $clog2(MX + 1);
  localparam int EW  = BLOCK_BITS + 2;
  localparam int TOT_XY = CHUNK_SIZE * CHUNK_HEIGHT;
  localparam int TOT_Z  = CHUNK_SIZE * CHUNK_SIZE;

  logic [BLOCK_BITS-1:0] vmem [SD];
  logic [EW-1:0]         mmem [MD];

  logic [BLOCK_BITS-1:0] vrd0, vrd1;
  logic [EW-1:0]         mrd;
  logic                  vwe, mwe;
  logic [VW-1:0]         vwa, va0, va1;
  logic [BLOCK_BITS-1:0] vwd;
  logic [MW-1:0]         mwa, mra;
  logic [EW-1:0]         mwd;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwa] <= vwd;
    end
    vrd0 <= vmem[va0];
    vrd1 <= vmem[va1];
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      mmem[mwa] <= mwd;
    end
    mrd <= mmem[mra];
  end

  state_t state, state_next;
  logic [AIR_BITS-1:0] air_code;
  logic       active, active_next;
  logic       fetching, fetching_next;
  logic [1:0] axis, axis_next;
  logic [LW-1:0] bnd, bnd_next;
  logic [MW-1:0] n, n_next;
  logic [LW-1:0] ci, ci_next, cj, cj_next;
  logic [LW-1:0] w, w_next, h, h_next, k, k_next, r, r_next;
  logic [MW-1:0] rowbase, rowbase_next;
  logic [EW-1:0] cur, cur_next;
  logic          out_valid_next;
  logic [OUT_BITS-1:0] out_data_next;

  logic [31:0] lim, l1, l2, tot;
  logic [LW-1:0] cx, cy, cz, dx, dy, dz;
  logic [LW-1:0] ox, oy, oz;
  logic [BLOCK_BITS-1:0] air_m;
  logic s0, s1, same, out_free;
  logic [3:0] vx, vy;
  logic [8:0] vz;

  function automatic logic [VW-1:0] vaddr(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z);
    return VW'((z * CHUNK_SIZE + y) * CHUNK_SIZE + x);
  endfunction

  assign air_m    = BLOCK_BITS'(air_code);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign vx = s_tdata[3:0];
  assign vy = s_tdata[7:4];
  assign vz = s_tdata[16:8];
  assign same = mrd[0] && (mrd[1] == cur[1]) && (mrd[EW-1:2] == cur[EW-1:2]);

  always_comb begin
    case (axis)
      AXIS_X: begin
        lim = 32'(CHUNK_SIZE); l1 = 32'(CHUNK_SIZE); l2 = 32'(CHUNK_HEIGHT);
        tot = 32'(TOT_XY);
        cx = bnd - 1'b1; cy = ci; cz = cj; dx = bnd; dy = ci; dz = cj;
        ox = bnd; oy = ci; oz = cj;
      end
      AXIS_Y: begin
        lim = 32'(CHUNK_SIZE); l1 = 32'(CHUNK_HEIGHT); l2 = 32'(CHUNK_SIZE);
        tot = 32'(TOT_XY);
        cx = cj; cy = bnd - 1'b1; cz = ci; dx = cj; dy = bnd; dz = ci;
        ox = cj; oy = bnd; oz = ci;
      end
      default: begin
        lim = 32'(CHUNK_HEIGHT); l1 = 32'(CHUNK_SIZE); l2 = 32'(CHUNK_SIZE);
        tot = 32'(TOT_Z);
        cx = ci; cy = cj; cz = bnd - 1'b1; dx = ci; dy = cj; dz = bnd;
        ox = ci; oy = cj; oz = bnd;
      end
    endcase
  end

  assign s0 = (bnd != '0) && (vrd0 != air_m);
  assign s1 = (32'(bnd) != lim) && (vrd1 != air_m);

  always_comb begin
    state_next     = state;
    active_next    = active;
    fetching_next  = fetching;
    axis_next      = axis;
    bnd_next       = bnd;
    n_next         = n;
    ci_next        = ci;
    cj_next        = cj;
    w_next         = w;
    h_next         = h;
    k_next         = k;
    r_next         = r;
    rowbase_next   = rowbase;
    cur_next       = cur;
    out_valid_next = m_tvalid && !m_tready;
    out_data_next  = m_tdata;
    vwe = 1'b0;
    vwa = vaddr(32'(vx), 32'(vy), 32'(vz));
    vwd = BLOCK_BITS'(s_tdata[22:17]);
    va0 = vaddr(32'(cx), 32'(cy), 32'(cz));
    va1 = vaddr(32'(dx), 32'(dy), 32'(dz));
    mwe = 1'b0;
    mwa = n;
    mwd = '0;
    mra = n;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            ACT_WRITE: begin
              vwe = (32'(vx) < CHUNK_SIZE) && (32'(vy) < CHUNK_SIZE) &&
                    (32'(vz) < CHUNK_HEIGHT);
            end
            ACT_RESTART: begin
              axis_next = AXIS_X; bnd_next = '0; active_next = 1'b1;
              n_next = '0; ci_next = '0; cj_next = '0; fetching_next = 1'b0;
              state_next = ST_BRD;
            end
            ACT_FETCH: begin
              fetching_next = 1'b1;
              state_next = active ? ST_SRD : ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BRD: state_next = ST_BWR;
      ST_BWR: begin
        mwe = 1'b1;
        mwd = {(s0 != s1) ? (s0 ? vrd0 : vrd1) : BLOCK_BITS'(0), s0 && !s1, s0 != s1};
        if (32'(n) == tot - 1) begin
          n_next = '0; ci_next = '0; cj_next = '0;
          state_next = fetching ? ST_SRD : ST_IDLE;
        end else begin
          n_next = n + 1'b1;
          if (32'(ci) == l1 - 1) begin
            ci_next = '0; cj_next = cj + 1'b1;
          end else begin
            ci_next = ci + 1'b1;
          end
          state_next = ST_BRD;
        end
      end
      ST_SRD: begin
        state_next = (32'(n) < tot) ? ST_SCHK : ST_ADV;
      end
      ST_SCHK: begin
        if (!mrd[0]) begin
          n_next = n + 1'b1;
          if (32'(ci) == l1 - 1) begin
            ci_next = '0; cj_next = cj + 1'b1;
          end else begin
            ci_next = ci + 1'b1;
          end
          state_next = ST_SRD;
        end else begin
          cur_next = mrd; w_next = LW'(1); state_next = ST_WRD;
        end
      end
      ST_WRD: begin
        mra = MW'(32'(n) + 32'(w));
        if (32'(ci) + 32'(w) < l1) begin
          state_next = ST_WCHK;
        end else begin
          h_next = LW'(1); k_next = '0; rowbase_next = MW'(32'(n) + l1);
          state_next = ST_HRD;
        end
      end
      ST_WCHK: begin
        if (same) begin
          w_next = w + 1'b1; state_next = ST_WRD;
        end else begin
          h_next = LW'(1); k_next = '0; rowbase_next = MW'(32'(n) + l1);
          state_next = ST_HRD;
        end
      end
      ST_HRD: begin
        mra = MW'(32'(rowbase) + 32'(k));
        if (32'(cj) + 32'(h) < l2) begin
          state_next = ST_HCHK;
        end else begin
          rowbase_next = n; k_next = '0; r_next = '0; state_next = ST_CLR;
        end
      end
      ST_HCHK: begin
        if (!same) begin
          rowbase_next = n; k_next = '0; r_next = '0; state_next = ST_CLR;
        end else if (k == w - 1'b1) begin
          h_next = h + 1'b1; k_next = '0;
          rowbase_next = MW'(32'(rowbase) + l1); state_next = ST_HRD;
        end else begin
          k_next = k + 1'b1; state_next = ST_HRD;
        end
      end
      ST_CLR: begin
        mwe = 1'b1;
        mwa = MW'(32'(rowbase) + 32'(k));
        mwd = '0;
        if (k == w - 1'b1) begin
          k_next = '0;
          if (r == h - 1'b1) begin
            state_next = ST_EMIT;
          end else begin
            r_next = r + 1'b1; rowbase_next = MW'(32'(rowbase) + l1);
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next = {1'b0, 9'(h), 9'(w), 9'(oz), 5'(oy), 5'(ox),
                           6'(cur[EW-1:2]), cur[1], axis, 1'b1};
          n_next = MW'(32'(n) + 32'(w));
          if (32'(ci) + 32'(w) == l1) begin
            ci_next = '0; cj_next = cj + 1'b1;
          end else begin
            ci_next = ci + w;
          end
          fetching_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_ADV: begin
        n_next = '0; ci_next = '0; cj_next = '0;
        if (32'(bnd) == lim) begin
          bnd_next = '0;
          if (axis == AXIS_Z) begin
            axis_next = AXIS_X; active_next = 1'b0; state_next = ST_DONE;
          end else begin
            axis_next = axis + 1'b1; state_next = ST_BRD;
          end
        end else begin
          bnd_next = bnd + 1'b1; state_next = ST_BRD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1; out_data_next = '0;
          fetching_next = 1'b0; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      active   <= 1'b0;
      fetching <= 1'b0;
      axis     <= AXIS_X;
      bnd      <= '0;
      n        <= '0;
      ci       <= '0;
      cj       <= '0;
      air_code <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      active   <= active_next;
      fetching <= fetching_next;
      axis     <= axis_next;
      bnd      <= bnd_next;
      n        <= n_next;
      ci       <= ci_next;
      cj       <= cj_next;
      m_tvalid <= out_valid_next;
      if (cfg_we) begin
        air_code <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    w       <= w_next;
    h       <= h_next;
    k       <= k_next;
    r       <= r_next;
    rowbase <= rowbase_next;
    cur     <= cur_next;
    m_tdata <= out_data_next;
  end

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT || state == ST_DONE) && out_free) |=> m_tvalid)
    else $error("result not loaded into output register");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCHK) |-> (32'(n) < tot))
    else $error("scan cursor beyond mask");

  a_width_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HRD || state == ST_CLR) |-> (w != '0 && 32'(ci) + 32'(w) <= l1))
    else $error("quad width out of row");

  a_fetch_only_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRD) |-> active)
    else $error("scan while sweep finished");

endmodule

### sim/voxel_greedy_mesher_tb.sv
module voxel_greedy_mesher_tb;
  import vgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CS = 16;
  localparam int CH = 384;
  localparam int STORE_N = CS * CS * CH;
  localparam int MASK_N = CS * CH;
  localparam int STALL_LIMIT = 6000000;
  localparam logic [1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [8:0] s2;
    logic [8:0] s1;
    logic [8:0] cz;
    logic [4:0] cy;
    logic [4:0] cx;
    logic [5:0] blk;
    logic       pos;
    logic [1:0] axis;
    logic       qv;
  } quad_t;

  typedef struct packed {
    logic       present;
    logic       pos;
    logic [5:0] blk;
  } face_t;

  typedef struct {
    logic [1:0] act;
    int         x, y, z, blk;
    bit         typed;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic [1:0] s_tuser = ACT_WRITE;
  logic m_tvalid;
  logic m_tready = 1;
  logic [OUT_BITS-1:0] m_tdata;
  logic cfg_we = 0;
  logic [AIR_BITS-1:0] cfg_data = '0;

  // travels with the item: use the typed-in expectation instead of the predictor
  bit typed_on = 0;
  bit quiet = 0;
  int idle_odds = 15;
  int errors = 0;
  int stall_cnt = 0;

  logic [5:0] chunk[STORE_N];
  face_t faces[MASK_N];
  int cur_axis, cur_slice, cursor;
  bit sweeping;
  logic [5:0] air;
  quad_t quads_due[$];

  always #4 clk = ~clk;

  voxel_greedy_mesher u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  function automatic int span_of(int a);
    return a == 2 ? CH : CS;
  endfunction

  function automatic bit solid(int c[3], output logic [5:0] b);
    b = '0;
    if (c[0] < 0 || c[1] < 0 || c[2] < 0 || c[0] >= CS || c[1] >= CS || c[2] >= CH)
      return 0;
    b = chunk[(c[2] * CS + c[1]) * CS + c[0]];
    return b != air;
  endfunction

  function automatic void build_faces();
    int a1, a2, l1, l2, n;
    int c[3], d[3];
    logic [5:0] b0, b1;
    bit s0, s1;
    a1 = (cur_axis + 1) % 3;
    a2 = (cur_axis + 2) % 3;
    l1 = span_of(a1);
    l2 = span_of(a2);
    n = 0;
    for (int j = 0; j < l2; j++) begin
      for (int i = 0; i < l1; i++) begin
        c[cur_axis] = cur_slice;
        c[a1] = i;
        c[a2] = j;
        d = c;
        d[cur_axis] = cur_slice + 1;
        s0 = solid(c, b0);
        s1 = solid(d, b1);
        faces[n].present = s0 != s1;
        faces[n].pos = s0 && !s1;
        faces[n].blk = (s0 != s1) ? (s0 ? b0 : b1) : '0;
        n++;
      end
    end
    cursor = 0;
  endfunction

  function automatic bit same_face(face_t p, face_t q);
    return p.present && q.present && p.pos == q.pos && p.blk == q.blk;
  endfunction

  function automatic bit take_quad(output quad_t q);
    int a1, a2, l1, l2, total, i, j, w, h;
    int c[3];
    bit done;
    face_t f;
    a1 = (cur_axis + 1) % 3;
    a2 = (cur_axis + 2) % 3;
    l1 = span_of(a1);
    l2 = span_of(a2);
    total = l1 * l2;
    q = '0;
    for (int n = cursor; n < total; n++) begin
      if (!faces[n].present) continue;
      f = faces[n];
      i = n % l1;
      j = n / l1;
      w = 1;
      while (i + w < l1 && same_face(faces[n + w], f)) w++;
      done = 0;
      for (h = 1; j + h < l2; h++) begin
        for (int k = 0; k < w; k++)
          if (!same_face(faces[n + k + h * l1], f)) done = 1;
        if (done) break;
      end
      for (int r = 0; r < h; r++)
        for (int k = 0; k < w; k++)
          faces[n + k + r * l1].present = 0;
      cursor = n + w;
      c[cur_axis] = cur_slice + 1;
      c[a1] = i;
      c[a2] = j;
      q.qv = 1;
      q.axis = cur_axis[1:0];
      q.pos = f.pos;
      q.blk = f.blk;
      q.cx = c[0][4:0];
      q.cy = c[1][4:0];
      q.cz = c[2][8:0];
      q.s1 = w[8:0];
      q.s2 = h[8:0];
      return 1;
    end
    cursor = total;
    return 0;
  endfunction

  function automatic quad_t next_quad();
    quad_t q;
    while (sweeping) begin
      if (take_quad(q)) return q;
      cur_slice++;
      if (cur_slice >= span_of(cur_axis)) begin
        cur_axis++;
        cur_slice = -1;
        if (cur_axis >= 3) begin
          cur_axis = 0;
          cursor = 0;
          sweeping = 0;
          break;
        end
      end
      build_faces();
    end
    return '0;
  endfunction

  function automatic void chk(string name, int e, int a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  initial begin
    for (int n = 0; n < MASK_N; n++) faces[n] = '0;
    cur_axis = 0;
    cur_slice = -1;
    cursor = 0;
    sweeping = 0;
    air = '0;
  end

  always @(posedge clk) begin
    quad_t e, g;
    int x, y, z;
    if (!rst) begin
      if (cfg_we) air <= cfg_data;
      if (s_tvalid && s_tready) begin
        x = s_tdata[3:0];
        y = s_tdata[7:4];
        z = s_tdata[16:8];
        case (s_tuser)
          ACT_WRITE: begin
            if (z < CH) chunk[(z * CS + y) * CS + x] = s_tdata[22:17];
          end
          ACT_RESTART: begin
            cur_axis = 0;
            cur_slice = -1;
            sweeping = 1;
            build_faces();
          end
          ACT_FETCH: begin
            e = next_quad();
            quads_due.push_back(typed_on ? quad_t'('0) : e);
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        g = m_tdata[46:0];
        if (quads_due.size() == 0) begin
          $error("quad with no expectation waiting: %h", m_tdata);
          errors++;
        end else begin
          e = quads_due.pop_front();
          chk("quad_valid", e.qv, g.qv);
          chk("sweep_axis", e.axis, g.axis);
          chk("facing_positive", e.pos, g.pos);
          chk("face_block", e.blk, g.blk);
          chk("corner_x", e.cx, g.cx);
          chk("corner_y", e.cy, g.cy);
          chk("corner_z", e.cz, g.cz);
          chk("span_first", e.s1, g.s1);
          chk("span_second", e.s2, g.s2);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_tready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send(logic [1:0] act, int x, int y, int z, int blk, bit typed = 0);
    if (!quiet && $urandom_range(0, idle_odds) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {1'b0, blk[5:0], z[8:0], y[3:0], x[3:0]};
    typed_on <= typed;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic set_air(logic [5:0] v);
    s_tvalid <= 0;
    @(posedge clk);
    while (quads_due.size() != 0 || !s_tready) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send(ACT_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 511), $urandom_range(0, 63));
    end else if (r < 5) begin
      send(ACT_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 511), $urandom_range(0, 63));
    end else if (r < 50) begin
      if ($urandom_range(0, 3) != 0)
        send(ACT_WRITE, 0, $urandom_range(0, 15), $urandom_range(0, 383),
             $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4));
      else
        send(ACT_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom_range(0, 511), $urandom_range(0, 63));
    end else begin
      send(ACT_FETCH, 0, 0, 0, 0);
    end
  endtask

  row_t rows[] = '{
    '{ACT_FETCH,   0,  0,   0,  0, 1},
    '{ACT_NOP,    15, 15, 511, 63, 0},
    '{ACT_WRITE,   3,  4, 400, 63, 0},
    '{ACT_WRITE,  15, 15, 511, 42, 0},
    // all-air chunk: the sweep runs out at once
    '{ACT_RESTART, 0,  0,   0,  0, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 1},
    '{ACT_FETCH,   0,  0,   0,  0, 1},
    '{ACT_WRITE,   0,  0,   0, 63, 0},
    '{ACT_WRITE,   1, 15, 383,  1, 0},
    '{ACT_WRITE,   0,  7, 200, 42, 0},
    '{ACT_WRITE,  15, 15, 383, 63, 0},
    '{ACT_WRITE,   0,  0, 384, 21, 0},
    '{ACT_RESTART, 0,  0,   0,  0, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 0},
    '{ACT_WRITE,   0,  3,   3, 22, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 0},
    '{ACT_FETCH,   0,  0,   0,  0, 0}
  };

  logic [5:0] airs[4];

  initial begin
    airs = '{6'd0, 6'd63, 6'd2, 6'($urandom_range(1, 62))};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_air(6'd0);
    for (int k = 0; k < 4; k++)
      send(rows[k].act, rows[k].x, rows[k].y, rows[k].z, rows[k].blk, rows[k].typed);
    idle_odds = 200;
    for (int z = 0; z < CH; z++)
      for (int y = 0; y < CS; y++)
        for (int x = 0; x < CS; x++)
          send(ACT_WRITE, x, y, z, 0);
    idle_odds = 15;
    for (int k = 4; k < rows.size(); k++)
      send(rows[k].act, rows[k].x, rows[k].y, rows[k].z, rows[k].blk, rows[k].typed);
    // solid wall at x = 0 of a few block kinds
    for (int z = 0; z < CH; z++)
      for (int y = 0; y < CS; y++)
        send(ACT_WRITE, 0, y, z, $urandom_range(1, 4));
    for (int p = 0; p < 4; p++) begin
      set_air(airs[p]);
      send(ACT_RESTART, 0, 0, 0, 0);
      for (int k = 0; k < 185; k++) begin
        if (p == 3 && k == 90) quiet = 1;
        random_item();
      end
      send(ACT_FETCH, 0, 0, 0, 0);
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (quads_due.size() != 0 || !s_tready) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
